FILE: hdl/rrs_pkg.sv
// ----------------------------------------------------------------------------
// rrs_pkg - round-robin scheduler shared types
// Transaction payloads, operation codes, sequencer states and register map.
// ----------------------------------------------------------------------------
`default_nettype none

package rrs_pkg;

    localparam int PID_W   = 4;
    localparam int BURST_W = 16;
    localparam int CNT_W   = 5;
    localparam int QUANT_W = 8;
    localparam int ADDR_W  = 3;
    localparam int DATA_W  = 32;

    localparam logic [QUANT_W-1:0] QUANTUM_RESET = 8'd5;
    localparam logic [QUANT_W-1:0] SLICE_MAX     = 8'd255;
    localparam logic [ADDR_W-1:0]  ADDR_QUANTUM  = 3'd0;

    typedef enum logic [1:0] {
        OP_ADMIT = 2'd0,
        OP_TICK  = 2'd1,
        OP_RAN   = 2'd2,
        OP_DONE  = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_WALK,
        S_DISP,
        S_POP,
        S_OUT
    } t_state;

    typedef struct packed {
        t_op                operation;
        logic [PID_W-1:0]   proc_id;
        logic [BURST_W-1:0] io_burst;
    } t_in;

    typedef struct packed {
        logic               running_valid;
        logic [PID_W-1:0]   running_proc;
        logic               switched;
        logic [CNT_W-1:0]   ready_count;
        logic [CNT_W-1:0]   waiting_count;
        logic               error;
    } t_out;

endpackage

`default_nettype wire

FILE: hdl/rrs_ram.sv
// ----------------------------------------------------------------------------
// rrs_ram - generic simple dual-port RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rrs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

FILE: hdl/round_robin_scheduler.sv
// ----------------------------------------------------------------------------
// round_robin_scheduler - round-robin CPU scheduler with I/O wait list
// Each transaction is accepted in the idle state and goes through the execute
// state to the output state. A timer tick first walks the wait list, reading
// one entry a cycle through the wait RAM port, then passes the dispatch state;
// a rotation or dispatch adds a ready-queue pop. The next transaction is taken
// while a result is pending, stalling only while the output register is full.
// Synchronous active-low reset: queues empty, CPU idle, quantum 5; no
// clearing pass, RAM contents undefined until written.
// ----------------------------------------------------------------------------
`default_nettype none

module round_robin_scheduler #(
    parameter int NUM_PROCS = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_ready,
    input  wire rrs_pkg::t_in                i_in_data,
    output logic                             o_out_valid,
    input  wire logic                        i_out_ready,
    output rrs_pkg::t_out                    o_out_data,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [rrs_pkg::ADDR_W-1:0]  paddr,
    input  wire logic [rrs_pkg::DATA_W-1:0]  pwdata,
    output logic      [rrs_pkg::DATA_W-1:0]  prdata,
    output logic                             pready
);

    localparam int IW = $clog2(NUM_PROCS);
    localparam int CW = $clog2(NUM_PROCS + 1);
    localparam int SW = CW + 1;
    localparam int WW = rrs_pkg::PID_W + rrs_pkg::BURST_W;

    localparam logic [CW-1:0] FULL  = CW'(NUM_PROCS);
    localparam logic [SW-1:0] DEPTH = SW'(NUM_PROCS);
    localparam logic [IW-1:0] LAST  = IW'(NUM_PROCS - 1);

    rrs_pkg::t_state              r_state, n_state;
    logic [rrs_pkg::QUANT_W-1:0]  r_quantum, n_quantum;
    logic [IW-1:0]                r_head, n_head;
    logic [CW-1:0]                r_rsize, n_rsize;
    logic [CW-1:0]                r_wsize, n_wsize;
    logic [rrs_pkg::PID_W-1:0]    r_cur, n_cur;
    logic                         r_cvalid, n_cvalid;
    logic [rrs_pkg::QUANT_W-1:0]  r_slice, n_slice;
    rrs_pkg::t_op                 r_op, n_op;
    logic [rrs_pkg::PID_W-1:0]    r_pid, n_pid;
    logic [rrs_pkg::BURST_W-1:0]  r_io, n_io;
    logic                         r_pvalid, n_pvalid;
    logic [rrs_pkg::PID_W-1:0]    r_pproc, n_pproc;
    logic                         r_err, n_err;
    logic                         r_rot, n_rot;
    logic [CW-1:0]                r_i, n_i;
    logic [CW-1:0]                r_k, n_k;
    rrs_pkg::t_out                r_out, n_out;
    logic                         r_ovalid, n_ovalid;

    logic                         rq_we;
    logic [IW-1:0]                rq_waddr;
    logic [rrs_pkg::PID_W-1:0]    rq_wdata;
    logic [rrs_pkg::PID_W-1:0]    rq_rdata;
    logic                         wq_we;
    logic [IW-1:0]                wq_waddr;
    logic [WW-1:0]                wq_wdata;
    logic [IW-1:0]                wq_raddr;
    logic [WW-1:0]                wq_rdata;

    logic [SW-1:0]                tail_sum;
    logic [IW-1:0]                tail;
    logic [IW-1:0]                head_inc;
    logic [rrs_pkg::BURST_W-1:0]  w_rem;
    logic [rrs_pkg::BURST_W-1:0]  w_dec;
    logic [rrs_pkg::PID_W-1:0]    w_id;
    logic [rrs_pkg::QUANT_W-1:0]  slice_inc;
    logic [CW-1:0]                k_next;

    rrs_ram #(.WIDTH(rrs_pkg::PID_W), .DEPTH(NUM_PROCS)) u_ready_ram (
        .i_clk   (i_clk),
        .i_we    (rq_we),
        .i_waddr (rq_waddr),
        .i_wdata (rq_wdata),
        .i_raddr (r_head),
        .o_rdata (rq_rdata)
    );

    rrs_ram #(.WIDTH(WW), .DEPTH(NUM_PROCS)) u_wait_ram (
        .i_clk   (i_clk),
        .i_we    (wq_we),
        .i_waddr (wq_waddr),
        .i_wdata (wq_wdata),
        .i_raddr (wq_raddr),
        .o_rdata (wq_rdata)
    );

    assign tail_sum = SW'(r_head) + SW'(r_rsize);
    assign tail     = (tail_sum >= DEPTH) ? IW'(tail_sum - DEPTH) : IW'(tail_sum);
    assign head_inc = (r_head == LAST) ? '0 : r_head + 1'b1;
    assign wq_raddr = (r_i < FULL) ? IW'(r_i) : '0;
    assign w_id     = wq_rdata[WW-1 -: rrs_pkg::PID_W];
    assign w_rem    = wq_rdata[rrs_pkg::BURST_W-1:0];
    assign w_dec    = (w_rem != '0) ? w_rem - 1'b1 : w_rem;
    assign slice_inc = (r_slice < rrs_pkg::SLICE_MAX) ? r_slice + 1'b1 : r_slice;

    assign o_in_ready  = (r_state == rrs_pkg::S_IDLE);
    assign o_out_valid = r_ovalid;
    assign o_out_data  = r_out;
    assign pready      = 1'b1;
    assign prdata      = (paddr == rrs_pkg::ADDR_QUANTUM) ?
                         rrs_pkg::DATA_W'(r_quantum) : '0;

    always_comb begin
        n_state  = r_state;
        n_quantum = r_quantum;
        n_head   = r_head;
        n_rsize  = r_rsize;
        n_wsize  = r_wsize;
        n_cur    = r_cur;
        n_cvalid = r_cvalid;
        n_slice  = r_slice;
        n_op     = r_op;
        n_pid    = r_pid;
        n_io     = r_io;
        n_pvalid = r_pvalid;
        n_pproc  = r_pproc;
        n_err    = r_err;
        n_rot    = r_rot;
        n_i      = r_i;
        n_k      = r_k;
        n_out    = r_out;
        n_ovalid = r_ovalid && !i_out_ready;
        rq_we    = 1'b0;
        rq_waddr = tail;
        rq_wdata = r_cur;
        wq_we    = 1'b0;
        wq_waddr = IW'(r_wsize);
        wq_wdata = {r_cur, r_io};
        k_next   = r_k;

        if (psel && penable && pwrite && paddr == rrs_pkg::ADDR_QUANTUM) begin
            n_quantum = pwdata[rrs_pkg::QUANT_W-1:0];
        end

        unique case (r_state)
            rrs_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_op     = i_in_data.operation;
                    n_pid    = i_in_data.proc_id;
                    n_io     = i_in_data.io_burst;
                    n_pvalid = r_cvalid;
                    n_pproc  = r_cur;
                    n_err    = 1'b0;
                    n_i      = '0;
                    n_k      = '0;
                    n_state  = rrs_pkg::S_EXEC;
                end
            end
            rrs_pkg::S_EXEC: begin
                n_state = rrs_pkg::S_OUT;
                unique case (r_op)
                    rrs_pkg::OP_ADMIT: begin
                        if (r_rsize == FULL) begin
                            n_err = 1'b1;
                        end else begin
                            rq_we    = 1'b1;
                            rq_wdata = r_pid;
                            n_rsize  = r_rsize + 1'b1;
                        end
                    end
                    rrs_pkg::OP_TICK: begin
                        if (r_wsize != '0) begin
                            n_i     = CW'(1);
                            n_state = rrs_pkg::S_WALK;
                        end else begin
                            n_state = rrs_pkg::S_DISP;
                        end
                    end
                    rrs_pkg::OP_RAN: begin
                        if (!r_cvalid) begin
                            n_err = 1'b1;
                        end else begin
                            n_slice = slice_inc;
                            if (slice_inc >= r_quantum) begin
                                n_slice = '0;
                                if (r_rsize != '0) begin
                                    n_rot   = 1'b1;
                                    n_state = rrs_pkg::S_POP;
                                end
                            end
                        end
                    end
                    rrs_pkg::OP_DONE: begin
                        if (!r_cvalid) begin
                            n_err = 1'b1;
                        end else begin
                            n_slice = '0;
                            if (r_io != '0 && r_wsize != FULL) begin
                                wq_we   = 1'b1;
                                n_wsize = r_wsize + 1'b1;
                                if (r_rsize != '0) begin
                                    n_rot   = 1'b0;
                                    n_state = rrs_pkg::S_POP;
                                end else begin
                                    n_cur    = '0;
                                    n_cvalid = 1'b0;
                                end
                            end else begin
                                n_err = (r_io != '0);
                                if (r_rsize != '0) begin
                                    n_rot   = 1'b1;
                                    n_state = rrs_pkg::S_POP;
                                end
                            end
                        end
                    end
                    default: ;
                endcase
            end
            rrs_pkg::S_WALK: begin
                if (w_dec == '0 && r_rsize != FULL) begin
                    rq_we    = 1'b1;
                    rq_wdata = w_id;
                    n_rsize  = r_rsize + 1'b1;
                end else begin
                    wq_we    = 1'b1;
                    wq_waddr = IW'(r_k);
                    wq_wdata = {w_id, w_dec};
                    k_next   = r_k + 1'b1;
                end
                n_k = k_next;
                if (r_i < r_wsize) begin
                    n_i = r_i + 1'b1;
                end else begin
                    n_wsize = k_next;
                    n_state = rrs_pkg::S_DISP;
                end
            end
            rrs_pkg::S_DISP: begin
                n_state = rrs_pkg::S_OUT;
                if (!r_cvalid) begin
                    n_slice = '0;
                    if (r_rsize != '0) begin
                        n_rot   = 1'b0;
                        n_state = rrs_pkg::S_POP;
                    end else begin
                        n_cur = '0;
                    end
                end
            end
            rrs_pkg::S_POP: begin
                n_cur  = rq_rdata;
                n_head = head_inc;
                if (r_rot) begin
                    rq_we    = 1'b1;
                    rq_wdata = r_cur;
                end else begin
                    n_cvalid = 1'b1;
                    n_rsize  = r_rsize - 1'b1;
                end
                n_state = rrs_pkg::S_OUT;
            end
            rrs_pkg::S_OUT: begin
                if (!r_ovalid || i_out_ready) begin
                    n_out.running_valid = r_cvalid;
                    n_out.running_proc  = r_cvalid ? r_cur : '0;
                    n_out.switched      = (r_pvalid != r_cvalid) ||
                                          (r_cvalid && r_pproc != r_cur);
                    n_out.ready_count   = (rrs_pkg::CNT_W)'(r_rsize);
                    n_out.waiting_count = (rrs_pkg::CNT_W)'(r_wsize);
                    n_out.error         = r_err;
                    n_ovalid            = 1'b1;
                    n_state             = rrs_pkg::S_IDLE;
                end
            end
            default: n_state = rrs_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rrs_pkg::S_IDLE;
            r_quantum <= rrs_pkg::QUANTUM_RESET;
            r_head    <= '0;
            r_rsize   <= '0;
            r_wsize   <= '0;
            r_cur     <= '0;
            r_cvalid  <= 1'b0;
            r_slice   <= '0;
            r_op      <= rrs_pkg::OP_ADMIT;
            r_pvalid  <= 1'b0;
            r_pproc   <= '0;
            r_err     <= 1'b0;
            r_rot     <= 1'b0;
            r_i       <= '0;
            r_k       <= '0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_quantum <= n_quantum;
            r_head    <= n_head;
            r_rsize   <= n_rsize;
            r_wsize   <= n_wsize;
            r_cur     <= n_cur;
            r_cvalid  <= n_cvalid;
            r_slice   <= n_slice;
            r_op      <= n_op;
            r_pvalid  <= n_pvalid;
            r_pproc   <= n_pproc;
            r_err     <= n_err;
            r_rot     <= n_rot;
            r_i       <= n_i;
            r_k       <= n_k;
            r_ovalid  <= n_ovalid;
        end
    end

    // transaction payload, no reset needed
    always_ff @(posedge i_clk) begin
        r_pid <= n_pid;
        r_io  <= n_io;
        r_out <= n_out;
    end

endmodule

`default_nettype wire

FILE: verif/rrs_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// rrs_checker - scoreboard for the round-robin scheduler
// Keeps its own copy of the scheduler state and quantum register. Watches
// accepted input transactions and APB writes, predicts the status result of
// each transaction, and compares every returned result field by field with
// the oldest prediction. Reports the failure count and outstanding results.
// ----------------------------------------------------------------------------
`default_nettype none

module rrs_checker #(
    parameter int NUM_PROCS = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    input  wire logic                        i_in_ready,
    input  wire rrs_pkg::t_in                i_in_data,
    input  wire logic                        i_out_valid,
    input  wire logic                        i_out_ready,
    input  wire rrs_pkg::t_out               i_out_data,
    input  wire logic                        i_psel,
    input  wire logic                        i_penable,
    input  wire logic                        i_pwrite,
    input  wire logic [rrs_pkg::ADDR_W-1:0]  i_paddr,
    input  wire logic [rrs_pkg::DATA_W-1:0]  i_pwdata,
    input  wire logic                        i_pready,
    output int                               o_fail_count,
    output int                               o_pending,
    output int                               o_results
);

    import rrs_pkg::*;

    logic [PID_W-1:0]   rdy_ids [NUM_PROCS];
    int                 rdy_head;
    int                 rdy_size;
    logic [PID_W-1:0]   wt_ids  [NUM_PROCS];
    logic [BURST_W-1:0] wt_left [NUM_PROCS];
    int                 wt_size;
    logic [PID_W-1:0]   cpu_proc;
    logic               cpu_busy;
    logic [QUANT_W-1:0] slice;
    logic [QUANT_W-1:0] quantum;

    t_out predicted_status [$];
    t_out exp_res;
    logic bad;

    function automatic void ready_push(logic [PID_W-1:0] id);
        rdy_ids[(rdy_head + rdy_size) % NUM_PROCS] = id;
        rdy_size++;
    endfunction

    function automatic logic [PID_W-1:0] ready_pop();
        logic [PID_W-1:0] id;
        id = rdy_ids[rdy_head];
        rdy_head = (rdy_head + 1) % NUM_PROCS;
        rdy_size--;
        return id;
    endfunction

    function automatic void rotate_runner();
        logic [PID_W-1:0] nxt;
        if (rdy_size == 0) return;
        nxt = ready_pop();
        ready_push(cpu_proc);
        cpu_proc = nxt;
    endfunction

    function automatic void dispatch_or_idle();
        if (rdy_size != 0) begin
            cpu_proc = ready_pop();
            cpu_busy = 1'b1;
        end else begin
            cpu_proc = '0;
            cpu_busy = 1'b0;
        end
    endfunction

    function automatic t_out schedule_event(t_in txn);
        t_out             res;
        logic             prev_busy;
        logic [PID_W-1:0] prev_proc;
        logic             err;
        logic [BURST_W-1:0] left;
        int               i;
        int               k;
        prev_busy = cpu_busy;
        prev_proc = cpu_proc;
        err = 1'b0;
        case (txn.operation)
            OP_ADMIT: begin
                if (rdy_size >= NUM_PROCS) err = 1'b1;
                else ready_push(txn.proc_id);
            end
            OP_TICK: begin
                k = 0;
                for (i = 0; i < wt_size; i++) begin
                    left = wt_left[i];
                    if (left != '0) left = left - 1'b1;
                    if (left == '0 && rdy_size < NUM_PROCS) begin
                        ready_push(wt_ids[i]);
                    end else begin
                        wt_ids[k]  = wt_ids[i];
                        wt_left[k] = left;
                        k++;
                    end
                end
                wt_size = k;
                if (!cpu_busy) begin
                    dispatch_or_idle();
                    slice = '0;
                end
            end
            OP_RAN: begin
                if (!cpu_busy) begin
                    err = 1'b1;
                end else begin
                    if (slice != SLICE_MAX) slice = slice + 1'b1;
                    if (slice >= quantum) begin
                        rotate_runner();
                        slice = '0;
                    end
                end
            end
            default: begin
                if (!cpu_busy) begin
                    err = 1'b1;
                end else begin
                    if (txn.io_burst != '0 && wt_size < NUM_PROCS) begin
                        wt_ids[wt_size]  = cpu_proc;
                        wt_left[wt_size] = txn.io_burst;
                        wt_size++;
                        dispatch_or_idle();
                    end else begin
                        if (txn.io_burst != '0) err = 1'b1;
                        rotate_runner();
                    end
                    slice = '0;
                end
            end
        endcase
        res.running_valid = cpu_busy;
        res.running_proc  = cpu_busy ? cpu_proc : '0;
        res.switched      = (prev_busy != cpu_busy) || (cpu_busy && prev_proc != cpu_proc);
        res.ready_count   = CNT_W'(rdy_size);
        res.waiting_count = CNT_W'(wt_size);
        res.error         = err;
        return res;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            quantum      = QUANTUM_RESET;
            rdy_head     = 0;
            rdy_size     = 0;
            wt_size      = 0;
            cpu_proc     = '0;
            cpu_busy     = 1'b0;
            slice        = '0;
            o_fail_count = 0;
            o_results    = 0;
            predicted_status.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == ADDR_QUANTUM)
                quantum = i_pwdata[QUANT_W-1:0];
            if (i_in_valid && i_in_ready)
                predicted_status.push_back(schedule_event(i_in_data));
            if (i_out_valid && i_out_ready) begin
                o_results++;
                if (predicted_status.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("%0t: result with no transaction outstanding: %p",
                                 $realtime, i_out_data);
                end else begin
                    exp_res = predicted_status.pop_front();
                    bad = (exp_res.running_valid !== i_out_data.running_valid) ||
                          (exp_res.running_proc  !== i_out_data.running_proc)  ||
                          (exp_res.switched      !== i_out_data.switched)      ||
                          (exp_res.ready_count   !== i_out_data.ready_count)   ||
                          (exp_res.waiting_count !== i_out_data.waiting_count) ||
                          (exp_res.error         !== i_out_data.error);
                    if (bad) begin
                        o_fail_count++;
                        if (o_fail_count <= 10) begin
                            $display("%0t: mismatch on result %0d", $realtime, o_results);
                            $display("  exp valid=%0b proc=%0d sw=%0b rdy=%0d wait=%0d err=%0b",
                                     exp_res.running_valid, exp_res.running_proc,
                                     exp_res.switched, exp_res.ready_count,
                                     exp_res.waiting_count, exp_res.error);
                            $display("  got valid=%0b proc=%0d sw=%0b rdy=%0d wait=%0d err=%0b",
                                     i_out_data.running_valid, i_out_data.running_proc,
                                     i_out_data.switched, i_out_data.ready_count,
                                     i_out_data.waiting_count, i_out_data.error);
                        end
                    end
                end
            end
        end
        o_pending = predicted_status.size();
    end

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top - round-robin scheduler testbench
// Directed scheduler events from reset, then random episodes (admit bursts,
// I/O parking, long runs, tick drains, mixed traffic) across several quantum
// settings, with random idling on both handshake channels. Checking is done
// by rrs_checker beside the DUT.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    import rrs_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int RANDOM_ITEMS = 1500;
    localparam int QUIET_ITEMS  = 200;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                in_valid = 1'b0;
    logic                in_ready;
    t_in                 in_data = '0;
    logic                out_valid;
    logic                out_ready = 1'b1;
    t_out                out_data;
    logic                psel = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite = 1'b0;
    logic [ADDR_W-1:0]   paddr = '0;
    logic [DATA_W-1:0]   pwdata = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    int                  fail_count;
    int                  pending;
    int                  results;
    int                  cycles = 0;
    int                  sent = 0;
    int                  op_count [4] = '{0, 0, 0, 0};
    int                  out_stall = 0;
    logic                quiet = 1'b0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    round_robin_scheduler DUT (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_ready (in_ready),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_ready(out_ready),
        .o_out_data (out_data),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    rrs_checker u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_ready  (in_ready),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_ready (out_ready),
        .i_out_data  (out_data),
        .i_psel      (psel),
        .i_penable   (penable),
        .i_pwrite    (pwrite),
        .i_paddr     (paddr),
        .i_pwdata    (pwdata),
        .i_pready    (pready),
        .o_fail_count(fail_count),
        .o_pending   (pending),
        .o_results   (results)
    );

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d results outstanding", cycles, pending);
            $display("tb_top failed");
            $finish;
        end
    end

    // result-side backpressure in random bursts
    always @(negedge clk) begin
        if (!rst_n || quiet) begin
            out_ready = 1'b1;
        end else if (out_stall > 0) begin
            out_ready = 1'b0;
            out_stall--;
        end else if ($urandom_range(0, 5) == 0) begin
            out_ready = 1'b0;
            out_stall = $urandom_range(0, 4);
        end else begin
            out_ready = 1'b1;
        end
    end

    function automatic t_in mk(t_op op, logic [PID_W-1:0] pid, logic [BURST_W-1:0] io);
        t_in txn;
        txn.operation = op;
        txn.proc_id   = pid;
        txn.io_burst  = io;
        return txn;
    endfunction

    function automatic logic [BURST_W-1:0] pick_io();
        if ($urandom_range(0, 199) == 0) return BURST_W'($urandom);
        if ($urandom_range(0, 3) == 0) return '0;
        return BURST_W'($urandom_range(1, 6));
    endfunction

    task automatic send_txn(input t_in txn);
        int gap;
        @(negedge clk);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 5);
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        in_data  = txn;
        do @(posedge clk); while (!in_ready);
        sent++;
        op_count[int'(txn.operation)]++;
        if (sent > RANDOM_ITEMS + 26 - QUIET_ITEMS) quiet = 1'b1;
    endtask

    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic apb_write(input logic [ADDR_W-1:0] addr, input logic [DATA_W-1:0] data);
        @(negedge clk);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = addr;
        pwdata  = data;
        @(negedge clk);
        penable = 1'b1;
        do @(posedge clk); while (!pready);
        @(negedge clk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic run_episode(input int kind);
        int n;
        int j;
        int r;
        case (kind)
            0: begin
                n = $urandom_range(16, 22);
                for (j = 0; j < n; j++)
                    send_txn(mk(OP_ADMIT, PID_W'($urandom), '0));
            end
            1: begin
                n = $urandom_range(4, 12);
                for (j = 0; j < n; j++) begin
                    send_txn(mk(OP_ADMIT, PID_W'($urandom), BURST_W'($urandom)));
                    send_txn(mk(OP_DONE, PID_W'($urandom),
                                BURST_W'($urandom_range(1, 40))));
                end
            end
            2: begin
                n = $urandom_range(10, 40);
                for (j = 0; j < n; j++) begin
                    if ($urandom_range(0, 99) < 85)
                        send_txn(mk(OP_RAN, PID_W'($urandom), BURST_W'($urandom)));
                    else
                        send_txn(mk(OP_DONE, PID_W'($urandom), '0));
                end
            end
            3: begin
                n = $urandom_range(5, 30);
                for (j = 0; j < n; j++) begin
                    r = $urandom_range(0, 9);
                    if (r < 8)
                        send_txn(mk(OP_TICK, PID_W'($urandom), BURST_W'($urandom)));
                    else if (r == 8)
                        send_txn(mk(OP_DONE, PID_W'($urandom), BURST_W'($urandom_range(0, 3))));
                    else
                        send_txn(mk(OP_RAN, PID_W'($urandom), '0));
                end
            end
            default: begin
                for (j = 0; j < 20; j++)
                    send_txn(mk(t_op'($urandom_range(0, 3)), PID_W'($urandom), pick_io()));
            end
        endcase
    endtask

    logic [QUANT_W-1:0] quanta [6] = '{8'd1, 8'd0, 8'd255, 8'd3, 8'd128, 8'd2};
    int                 phase;
    int                 kind;
    int                 k;
    int                 budget;

    initial begin
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // idle CPU: run events refused, empty tick
        send_txn(mk(OP_RAN, 4'd0, 16'd0));
        send_txn(mk(OP_DONE, 4'd15, 16'hFFFF));
        send_txn(mk(OP_TICK, 4'd0, 16'd0));
        // lone runner hits the quantum with nothing ready
        send_txn(mk(OP_ADMIT, 4'd0, 16'd0));
        send_txn(mk(OP_TICK, 4'd0, 16'd0));
        for (k = 0; k < 5; k++) send_txn(mk(OP_RAN, 4'd0, 16'd0));
        send_txn(mk(OP_ADMIT, 4'd15, 16'hFFFF));
        send_txn(mk(OP_ADMIT, 4'd10, 16'd0));
        send_txn(mk(OP_RAN, 4'd0, 16'd0));
        send_txn(mk(OP_DONE, 4'd0, 16'd0));
        send_txn(mk(OP_DONE, 4'd0, 16'hFFFF));
        send_txn(mk(OP_DONE, 4'd0, 16'd1));
        send_txn(mk(OP_TICK, 4'd0, 16'd0));
        send_txn(mk(OP_DONE, 4'd0, 16'd2));
        send_txn(mk(OP_DONE, 4'd0, 16'd0));
        send_txn(mk(OP_TICK, 4'd0, 16'd0));
        send_txn(mk(OP_TICK, 4'd0, 16'd0));
        send_txn(mk(OP_DONE, 4'd0, 16'd3));
        send_txn(mk(OP_DONE, 4'd0, 16'd4));
        send_txn(mk(OP_TICK, 4'd0, 16'd0));
        send_txn(mk(OP_ADMIT, 4'd5, 16'h5555));

        for (phase = 0; phase < 6; phase++) begin
            drain();
            apb_write(ADDR_QUANTUM, DATA_W'(quanta[phase]));
            budget = sent + RANDOM_ITEMS / 6;
            if (quanta[phase] == 8'd255) begin
                for (k = 0; k < 262; k++)
                    send_txn(mk(OP_RAN, PID_W'($urandom), '0));
            end
            while (sent < budget) begin
                kind = $urandom_range(0, 4);
                // keep occupancy low early on, since processes never leave
                if (kind == 0 && phase < 3) kind = 4;
                run_episode(kind);
            end
        end

        drain();
        repeat (30) @(posedge clk);
        $display("Sent %0d transactions: %0d admit, %0d tick, %0d ran, %0d burst done",
                 sent, op_count[0], op_count[1], op_count[2], op_count[3]);
        $display("Checked %0d results over %0d quantum settings, %0d mismatches",
                 results, 7, fail_count);
        if (fail_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
